>>> rtl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  localparam int unsigned SIG_COUNT    = 19;
  localparam int unsigned SIG_MAX_LEN  = 16;
  localparam int unsigned HIST_DEPTH   = SIG_MAX_LEN - 1;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned MAX_PER_ITEM = 5;

  localparam int unsigned ID_W     = 5;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned CONF_W   = 7;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SKIP_W   = 4;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned NBYTE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  CAP_RESET = 16'd1024;
  localparam logic [CONF_W-1:0] THR_RESET = 7'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RESULTS = 2'd0,
    CFG_SUSP_THR    = 2'd1
  } cfg_idx_e;

  // signature byte k sits at bits [8*(SIG_MAX_LEN-1-k) +: 8], zero padded on the right
  typedef logic [8*SIG_MAX_LEN-1:0] sig_bytes_t;
  // window byte d is the byte d positions back, d = 0 being the current one
  typedef logic [SIG_MAX_LEN-1:0][7:0] win_t;

  localparam sig_bytes_t SIG_BYTES [SIG_COUNT] = '{
    {8'h4D, 8'h5A, 112'h0},
    {8'h7F, 8'h45, 8'h4C, 8'h46, 96'h0},
    {8'h50, 8'h45, 8'h00, 8'h00, 96'h0},
    {8'h90, 8'h90, 8'h90, 8'h90, 96'h0},
    {8'hE8, 8'h00, 8'h00, 8'h00, 8'h00, 88'h0},
    {8'hEB, 8'h00, 112'h0},
    {8'h61, 120'h0},
    {8'h61, 120'h0},
    128'h0,
    {8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 72'h0},
    {8'h68, 8'h74, 8'h74, 8'h70, 8'h73, 8'h3A, 8'h2F, 8'h2F, 64'h0},
    {8'h40, 120'h0},
    {8'h00, 8'h00, 8'h00, 8'h00, 96'h0},
    {8'h34, 120'h0},
    {8'h70, 8'h61, 8'h73, 8'h73, 8'h77, 8'h6F, 8'h72, 8'h64, 64'h0},
    {8'hDE, 8'hAD, 8'hBE, 8'hEF, 96'h0},
    {8'hCC, 120'h0},
    {8'hCD, 8'h80, 112'h0},
    {8'hCD, 8'h2E, 112'h0}
  };

  localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
    5'd2, 5'd4, 5'd4, 5'd4, 5'd5, 5'd2, 5'd1, 5'd1, 5'd16, 5'd7,
    5'd8, 5'd1, 5'd4, 5'd1, 5'd8, 5'd4, 5'd1, 5'd2, 5'd2
  };

  localparam logic SIG_MAL [SIG_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0
  };

  localparam logic [CONF_W-1:0] SIG_CONF [SIG_COUNT] = '{
    7'd95, 7'd95, 7'd95, 7'd80, 7'd75, 7'd70, 7'd65, 7'd65, 7'd60, 7'd90,
    7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd95, 7'd90, 7'd85, 7'd85
  };

  // hit vector of one accepted byte, handed from the matcher to the emitter
  typedef struct packed {
    logic                 valid;
    logic [SIG_COUNT-1:0] mask;
    logic [OFFSET_W-1:0]  pos;
    logic                 last;
  } hit_t;

  function automatic logic sig_hit(input logic [ID_W-1:0] p, input win_t win);
    logic       ok;
    logic [3:0] bi;
    ok = 1'b1;
    for (int d = 0; d < SIG_MAX_LEN; d++) begin
      bi = 4'(SIG_MAX_LEN - int'(SIG_LEN[p]) + d);
      if (d < int'(SIG_LEN[p]) && win[d] != SIG_BYTES[p][{bi, 3'b000} +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> rtl/sps_in_if.sv
`timescale 1ns / 1ps

interface sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> rtl/sps_out_if.sv
`timescale 1ns / 1ps

interface sps_out_if;
  import sps_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     pattern_id;
  logic [OFFSET_W-1:0] match_offset;
  logic [LEN_W-1:0]    match_length;
  logic                malicious;
  logic                suspicious;
  logic [CONF_W-1:0]   confidence;
  logic [CNT_W-1:0]    result_number;
  logic                last_of_item;

  modport source (
    output valid, output pattern_id, output match_offset, output match_length,
    output malicious, output suspicious, output confidence, output result_number,
    output last_of_item, input ready
  );
  modport sink (
    input valid, input pattern_id, input match_offset, input match_length,
    input malicious, input suspicious, input confidence, input result_number,
    input last_of_item, output ready
  );
endinterface

>>> rtl/signature_pattern_scanner.sv
`timescale 1ns / 1ps

// Byte signature scanner. Bytes of a buffer enter on in_i (valid/ready), the
// final byte marked by end_of_buffer. Each byte is compared against all 19
// signatures in parallel; every find, up to 5 per byte and the result cap per
// buffer, leaves on out_o as one transaction with pattern, start offset,
// length, flags, confidence and a one-based result number; last_of_item
// marks the final transaction caused by a byte.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write the result cap (index 0) and the
// suspicious threshold (index 1); write them only while the block is idle.
// A byte's hit vector is registered, then each find in the result register.
// Throughput: one byte per cycle while out_o.ready is high and a byte has at
// most one reported find; a byte with k reported finds (k <= 5) holds
// in_i.ready low while the single result register issues them one per cycle.
// Reset clears history, position, block counters and result count, sets the
// cap to 1024 and the threshold to 80. When out_o.ready is low the result
// register holds and in_i.ready drops as soon as the pending find must wait.
module signature_pattern_scanner (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sps_in_if.sink                             in_i,
  sps_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import sps_pkg::*;

  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [CONF_W-1:0] thr_q, thr_d;
  hit_t              hit;
  logic              free;

  always_comb begin
    cap_d = cap_q;
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_RESULTS: cap_d = cfg_wdata_i[CNT_W-1:0];
        CFG_SUSP_THR:    thr_d = cfg_wdata_i[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      thr_q <= THR_RESET;
    end else begin
      cap_q <= cap_d;
      thr_q <= thr_d;
    end
  end

  sps_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .free_i (free),
    .hit_o  (hit)
  );

  sps_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hit),
    .cap_i  (cap_q),
    .thr_i  (thr_q),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

>>> rtl/sps_match.sv
`timescale 1ns / 1ps

module sps_match (
  input  logic          clk_i,
  input  logic          rst_ni,
  sps_in_if.sink        in_i,
  input  logic          free_i,
  output sps_pkg::hit_t hit_o
);
  import sps_pkg::*;

  logic [7:0]           hist_q [HIST_DEPTH];
  logic [7:0]           hist_d [HIST_DEPTH];
  logic [OFFSET_W-1:0]  pos_q, pos_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [SKIP_W-1:0]    skip_q [SIG_COUNT];
  logic [SKIP_W-1:0]    skip_d [SIG_COUNT];
  logic [SKIP_W-1:0]    skip_nxt [SIG_COUNT];
  logic [SIG_COUNT-1:0] hit;
  logic [FILL_W-1:0]    seen;
  win_t                 win;
  logic                 acc;

  assign acc        = in_i.valid & free_i;
  assign in_i.ready = free_i;

  always_comb begin
    win[0] = in_i.data_byte;
    for (int d = 1; d < SIG_MAX_LEN; d++) begin
      win[d] = hist_q[d-1];
    end
  end

  assign seen = (fill_q < FILL_W'(SIG_MAX_LEN)) ? fill_q + 1'b1 : FILL_W'(SIG_MAX_LEN);

  // all signatures compared in parallel; a blocked signature only counts down
  always_comb begin
    for (int p = 0; p < SIG_COUNT; p++) begin
      if (skip_q[p] != '0) begin
        hit[p]      = 1'b0;
        skip_nxt[p] = skip_q[p] - 1'b1;
      end else begin
        hit[p]      = (seen >= SIG_LEN[p]) && sig_hit(ID_W'(p), win);
        skip_nxt[p] = hit[p] ? SKIP_W'(SIG_LEN[p] - 1'b1) : '0;
      end
    end
  end

  always_comb begin
    hist_d = hist_q;
    pos_d  = pos_q;
    fill_d = fill_q;
    skip_d = skip_q;
    if (acc) begin
      if (in_i.end_of_buffer) begin
        for (int i = 0; i < HIST_DEPTH; i++) hist_d[i] = '0;
        for (int p = 0; p < SIG_COUNT; p++) skip_d[p] = '0;
        pos_d  = '0;
        fill_d = '0;
      end else begin
        hist_d[0] = in_i.data_byte;
        for (int i = 1; i < HIST_DEPTH; i++) hist_d[i] = hist_q[i-1];
        skip_d = skip_nxt;
        pos_d  = pos_q + 1'b1;
        fill_d = seen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
      for (int p = 0; p < SIG_COUNT; p++) skip_q[p] <= '0;
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      hist_q <= hist_d;
      skip_q <= skip_d;
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  assign hit_o.valid = acc;
  assign hit_o.mask  = hit;
  assign hit_o.pos   = pos_q;
  assign hit_o.last  = in_i.end_of_buffer;

endmodule

>>> rtl/sps_emit.sv
`timescale 1ns / 1ps

module sps_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sps_pkg::hit_t             hit_i,
  input  logic [sps_pkg::CNT_W-1:0]  cap_i,
  input  logic [sps_pkg::CONF_W-1:0] thr_i,
  output logic                      free_o,
  sps_out_if.source                 out_o
);
  import sps_pkg::*;

  logic                 pipe_valid_q, pipe_valid_d;
  logic [SIG_COUNT-1:0] mask_q, mask_d;
  logic [OFFSET_W-1:0]  pos_q, pos_d;
  logic                 last_q, last_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NBYTE_W-1:0]   nbyte_q, nbyte_d;

  logic                 out_valid_q, out_valid_d;
  logic [ID_W-1:0]      id_q;
  logic [OFFSET_W-1:0]  off_q;
  logic [LEN_W-1:0]     len_q;
  logic                 mal_q, susp_q, lst_q;
  logic [CONF_W-1:0]    conf_q;
  logic [CNT_W-1:0]     num_q;

  logic [ID_W-1:0]      first;
  logic [SIG_COUNT-1:0] mask_rest;
  logic                 can_report, active, emit, rest_active, done, out_free;

  // lowest pending signature goes first
  always_comb begin
    first = '0;
    for (int p = SIG_COUNT - 1; p >= 0; p--) begin
      if (mask_q[p]) first = ID_W'(p);
    end
  end

  always_comb begin
    mask_rest        = mask_q;
    mask_rest[first] = 1'b0;
  end

  assign can_report  = (cnt_q < cap_i) && (nbyte_q < NBYTE_W'(MAX_PER_ITEM));
  assign active      = pipe_valid_q && (|mask_q) && can_report;
  assign out_free    = !out_valid_q || out_o.ready;
  assign emit        = active && out_free;
  assign rest_active = (|mask_rest)
                     && (({1'b0, cnt_q} + 1'b1) < {1'b0, cap_i})
                     && (nbyte_q < NBYTE_W'(MAX_PER_ITEM - 1));
  // drop the rest of the vector at once when nothing more can be reported
  assign done        = pipe_valid_q && (!active || (emit && !rest_active));
  assign free_o      = !pipe_valid_q || done;

  always_comb begin
    pipe_valid_d = pipe_valid_q;
    mask_d       = mask_q;
    pos_d        = pos_q;
    last_d       = last_q;
    nbyte_d      = nbyte_q;
    cnt_d        = cnt_q;
    if (done && last_q) begin
      cnt_d = '0;
    end else if (emit) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (hit_i.valid) begin
      pipe_valid_d = 1'b1;
      mask_d       = hit_i.mask;
      pos_d        = hit_i.pos;
      last_d       = hit_i.last;
      nbyte_d      = '0;
    end else if (done) begin
      pipe_valid_d = 1'b0;
    end else if (emit) begin
      mask_d  = mask_rest;
      nbyte_d = nbyte_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      cnt_q        <= '0;
      nbyte_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      cnt_q        <= cnt_d;
      nbyte_q      <= nbyte_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    if (emit) begin
      id_q   <= first;
      off_q  <= pos_q - OFFSET_W'(SIG_LEN[first] - 1'b1);
      len_q  <= SIG_LEN[first];
      mal_q  <= SIG_MAL[first];
      conf_q <= SIG_CONF[first];
      susp_q <= (SIG_CONF[first] >= thr_i);
      num_q  <= cnt_q + 1'b1;
      lst_q  <= !rest_active;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pattern_id    = id_q;
  assign out_o.match_offset  = off_q;
  assign out_o.match_length  = len_q;
  assign out_o.malicious     = mal_q;
  assign out_o.suspicious    = susp_q;
  assign out_o.confidence    = conf_q;
  assign out_o.result_number = num_q;
  assign out_o.last_of_item  = lst_q;

endmodule
